// ===== hdl/fixed_partition_fit_allocator_macros.svh =====
// ============================================================================
// Assertion macros for the fixed partition fit allocator
// Concurrent checks on the clk / rst_n domain; empty when synthesizing.
// ============================================================================
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FPFA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FPFA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define FPFA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/fpfa_pkg.sv =====
// ============================================================================
// fpfa_pkg
// Codes, default sizes and channel payload types of the fit allocator.
// ============================================================================
`default_nettype none

package fpfa_pkg;

    // Default sizes of the partition table.
    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Field widths of the channels.
    localparam int OPCODE_W      = 2;
    localparam int ENTRY_W       = 4;
    localparam int AMOUNT_W      = 16;
    localparam int MODE_W        = 2;
    localparam int COUNT_W       = 5;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 5;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

    // Search policies.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE        = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_COUNT = 4'd1;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]  FIT_MODE_RST        = MODE_FIRST;
    localparam logic [COUNT_W-1:0] PARTITION_COUNT_RST = 5'd1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ENTRY_W-1:0]  entry_index;
        logic [AMOUNT_W-1:0] amount;
    } req_item_t;

    typedef struct packed {
        logic                granted;
        logic [ENTRY_W-1:0]  chosen_index;
        logic [AMOUNT_W-1:0] leftover;
    } rsp_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

endpackage

`default_nettype wire

// ===== hdl/fpfa_stream_if.sv =====
// ============================================================================
// fpfa_stream_if
// Valid/ready channel with a payload of a chosen type.
// ============================================================================
`default_nettype none

interface fpfa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/fpfa_cell.sv =====
// ============================================================================
// fpfa_cell
// One partition entry of the chain: holds its sizes and refines the passing
// search packet before handing it to the next cell.
// ============================================================================
`default_nettype none

module fpfa_cell #(
    parameter int  SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF,
    parameter int  IDX_W      = 4,
    parameter int  CELL_INDEX = 0,
    parameter type pkt_t      = logic,
    parameter type cmd_t      = logic
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [fpfa_pkg::COUNT_W-1:0] count,
    input  wire cmd_t                         cmd,
    input  wire pkt_t                         pkt_prev,
    output pkt_t                              pkt_reg
);

    logic [SIZE_BITS-1:0] orig_reg;
    logic [SIZE_BITS-1:0] free_reg;
    pkt_t                 pkt_next;
    logic                 active;
    logic                 fits;
    logic                 take;
    logic                 hit;

    assign active = 32'(count) > 32'(CELL_INDEX);
    assign fits   = free_reg >= pkt_prev.req;
    assign hit    = cmd.idx == IDX_W'(CELL_INDEX);

    always_comb
    begin
        case (pkt_prev.mode)
            fpfa_pkg::MODE_FIRST: take = fits && !pkt_prev.found;
            fpfa_pkg::MODE_BEST:
                take = fits && (!pkt_prev.found || free_reg < pkt_prev.best_f);
            fpfa_pkg::MODE_WORST:
                take = !pkt_prev.found || free_reg > pkt_prev.best_f;
            default: take = 1'b0;
        endcase
        take = take && pkt_prev.valid && active;

        pkt_next = pkt_prev;
        if (take)
        begin
            pkt_next.found    = 1'b1;
            pkt_next.best_idx = IDX_W'(CELL_INDEX);
            pkt_next.best_f   = free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg  <= '0;
            orig_reg <= '0;
            free_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (cmd.load_en && hit)
            begin
                orig_reg <= cmd.size;
                free_reg <= cmd.size;
            end
            else if (cmd.release_en)
            begin
                free_reg <= orig_reg;
            end
            else if (cmd.commit_en && hit)
            begin
                free_reg <= free_reg - cmd.size;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fixed_partition_fit_allocator.sv =====
// ============================================================================
// fixed_partition_fit_allocator
// Fixed partition table with first, best and worst fit allocation, built as
// a chain of entry cells that a search packet walks through.
// ============================================================================
//
//   Channel    Modport  Payload       Transfer
//   request    sink     req_item_t    valid && ready, one operation
//   response   source   rsp_item_t    valid && ready, one result
//   cfg        sink     cfg_write_t   valid && ready, one register write
//
// An allocate transfer sends the search packet through every cell of the
// chain before the next request can be taken: the result and the write-back
// of the chosen entry land in the same cycle, and moving the result into the
// output register, which can wait on a stalled response channel, frees the
// request side. Load, release, unused codes and an allocate under the unused
// fit mode skip the chain and write the result register directly.
// Reset clears every partition size to zero, selects first fit and one entry.
// A result that waits on a stalled response channel does not block the next
// request: the output register holds it while the next operation runs. Only
// when that next result is also waiting does the request side stall.
`default_nettype none

`include "fixed_partition_fit_allocator_macros.svh"

module fixed_partition_fit_allocator #(
    parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    fpfa_stream_if.sink    request,
    fpfa_stream_if.source  response,
    fpfa_stream_if.sink    cfg
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

    // Search packet that walks the chain, one cell per cycle.
    typedef struct packed {
        logic                        valid;
        logic [fpfa_pkg::MODE_W-1:0] mode;
        logic [SIZE_BITS-1:0]        req;
        logic                        found;
        logic [IDX_W-1:0]            best_idx;
        logic [SIZE_BITS-1:0]        best_f;
    } pkt_t;

    // Table update broadcast to every cell.
    typedef struct packed {
        logic                 load_en;
        logic                 release_en;
        logic                 commit_en;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } cmd_t;

    // Configuration registers.
    logic [fpfa_pkg::MODE_W-1:0]  fit_mode_reg;
    logic [fpfa_pkg::COUNT_W-1:0] count_reg;

    // Sequencing and result staging.
    logic                busy_reg;
    logic                busy_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    fpfa_pkg::rsp_item_t res_reg;
    fpfa_pkg::rsp_item_t res_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    fpfa_pkg::rsp_item_t out_reg;

    logic                 accept;
    logic                 launch;
    logic                 move;
    logic                 scan_ok;
    logic [SIZE_BITS-1:0] req_size;
    fpfa_pkg::req_item_t  req_item;
    cmd_t                 cmd;
    pkt_t                 pkt_chain [MAX_PARTITIONS+1];
    logic [MAX_PARTITIONS:0] pkt_valid_vec;

    // ------------------------------------------------------------------
    // Configuration port: always ready, writes to unknown indexes dropped.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= fpfa_pkg::FIT_MODE_RST;
            count_reg    <= fpfa_pkg::PARTITION_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.reg_index)
                fpfa_pkg::REG_FIT_MODE:
                    fit_mode_reg <= cfg.payload.data[fpfa_pkg::MODE_W-1:0];
                fpfa_pkg::REG_PARTITION_COUNT:
                    count_reg <= cfg.payload.data[fpfa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request side. One operation is in flight at a time; the request is
    // taken whenever no operation is running, even with a result pending
    // in the output register.
    // ------------------------------------------------------------------
    assign req_item      = request.payload;
    assign request.ready = !busy_reg;
    assign accept        = request.valid && !busy_reg;
    assign req_size      = SIZE_BITS'(req_item.amount);

    // An allocate with a defined fit mode sends a packet into the chain;
    // the unused fit mode never finds anything and answers at once.
    assign launch = accept && (req_item.opcode == fpfa_pkg::OP_ALLOC)
                    && (fit_mode_reg inside {fpfa_pkg::MODE_FIRST, fpfa_pkg::MODE_BEST,
                                             fpfa_pkg::MODE_WORST});

    always_comb
    begin
        pkt_chain[0]          = '0;
        pkt_chain[0].valid    = launch;
        pkt_chain[0].mode     = fit_mode_reg;
        pkt_chain[0].req      = req_size;
    end

    generate
        for (genvar g = 0; g < MAX_PARTITIONS; g++)
        begin : g_cell
            fpfa_cell #(
                .SIZE_BITS  (SIZE_BITS),
                .IDX_W      (IDX_W),
                .CELL_INDEX (g),
                .pkt_t      (pkt_t),
                .cmd_t      (cmd_t)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .count    (count_reg),
                .cmd      (cmd),
                .pkt_prev (pkt_chain[g]),
                .pkt_reg  (pkt_chain[g+1])
            );
        end
        for (genvar v = 0; v <= MAX_PARTITIONS; v++)
        begin : g_valid
            assign pkt_valid_vec[v] = pkt_chain[v].valid;
        end
    endgenerate

    // Worst fit carries the largest free size through the chain, so it only
    // succeeds if that size still covers the request.
    assign scan_ok = pkt_chain[MAX_PARTITIONS].found
                     && ((pkt_chain[MAX_PARTITIONS].mode != fpfa_pkg::MODE_WORST)
                         || (pkt_chain[MAX_PARTITIONS].best_f
                             >= pkt_chain[MAX_PARTITIONS].req));

    // ------------------------------------------------------------------
    // Table updates. Loads and releases apply in the cycle of the transfer;
    // the write-back of an allocation applies when the packet leaves the
    // last cell. Both cannot happen together since only one operation runs.
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd            = '0;
        cmd.load_en    = accept && (req_item.opcode == fpfa_pkg::OP_LOAD)
                         && (32'(req_item.entry_index) < MAX_PARTITIONS);
        cmd.release_en = accept && (req_item.opcode == fpfa_pkg::OP_RELEASE);
        cmd.idx        = IDX_W'(req_item.entry_index);
        cmd.size       = req_size;
        if (pkt_chain[MAX_PARTITIONS].valid)
        begin
            cmd.commit_en = scan_ok;
            cmd.idx       = pkt_chain[MAX_PARTITIONS].best_idx;
            cmd.size      = pkt_chain[MAX_PARTITIONS].req;
        end
    end

    // ------------------------------------------------------------------
    // Result staging: the result register collects the answer, the output
    // register presents it on the response channel.
    // ------------------------------------------------------------------
    assign move = res_valid_reg && (!out_valid_reg || response.ready);

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !move;
        busy_next      = (busy_reg || accept) && !move;
        out_valid_next = (out_valid_reg && !response.ready) || move;

        if (accept && !launch)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            res_next.granted = (req_item.opcode == fpfa_pkg::OP_LOAD)
                               || (req_item.opcode == fpfa_pkg::OP_RELEASE);
        end
        else if (pkt_chain[MAX_PARTITIONS].valid)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            if (scan_ok)
            begin
                res_next.granted      = 1'b1;
                res_next.chosen_index =
                    fpfa_pkg::ENTRY_W'(pkt_chain[MAX_PARTITIONS].best_idx);
                res_next.leftover     =
                    fpfa_pkg::AMOUNT_W'(pkt_chain[MAX_PARTITIONS].best_f
                                        - pkt_chain[MAX_PARTITIONS].req);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (move)
        begin
            out_reg <= res_reg;
        end
    end

    assign response.valid   = out_valid_reg;
    assign response.payload = out_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `FPFA_ASSERT_IMPLIES(a_single_packet, 1'b1, $countones(pkt_valid_vec) <= 1, "more than one search packet in the chain")
    `FPFA_ASSERT_IMPLIES(a_slot_free, pkt_chain[MAX_PARTITIONS].valid, busy_reg && !res_valid_reg, "search finished with the result slot taken")
    `FPFA_ASSERT_IMPLIES(a_result_busy, res_valid_reg, busy_reg, "pending result while idle")
    `FPFA_ASSERT_NEXT(a_accept_busy, accept, busy_reg, "operation not marked as running")

endmodule

`default_nettype wire

// ===== sim/fixed_partition_fit_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Fixed partition fit allocator testbench
// Drives load, allocate, release and unused operations through the request
// channel and rewrites the search policy and the entry count between phases.
// A behavioral copy of the partition table runs beside the block. It
// predicts every result at the moment its request is accepted, and each
// response transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed but the stimulus uses on purpose.
    localparam logic [fpfa_pkg::OPCODE_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic [fpfa_pkg::MODE_W-1:0]   MODE_UNUSED = 2'd3;

    localparam int TABLE_DEPTH = fpfa_pkg::MAX_PARTITIONS_DEF;
    localparam int AMOUNT_W    = fpfa_pkg::AMOUNT_W;
    localparam int COUNT_W     = fpfa_pkg::COUNT_W;
    localparam int MODE_W      = fpfa_pkg::MODE_W;
    localparam int ENTRY_W     = fpfa_pkg::ENTRY_W;

    // This pause outlasts the walk of a search packet through the whole chain,
    // so it is long enough for the block to settle once the last result has come back.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

    // The slowest correct stretch with no transfer at all is an allocate behind
    // a long receiver stall, or a settle pause. The watchdog limit takes that
    // many times over.
    localparam int STALL_LIMIT = 2000;

    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n;

    fpfa_stream_if #(.payload_t(fpfa_pkg::req_item_t))  req_if  ();
    fpfa_stream_if #(.payload_t(fpfa_pkg::rsp_item_t))  resp_if ();
    fpfa_stream_if #(.payload_t(fpfa_pkg::cfg_write_t)) cfg_if  ();

    fixed_partition_fit_allocator #(
        .MAX_PARTITIONS (fpfa_pkg::MAX_PARTITIONS_DEF),
        .SIZE_BITS      (fpfa_pkg::SIZE_BITS_DEF)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (resp_if),
        .cfg      (cfg_if)
    );

    // Shadow of the partition table and of the two registers.
    logic [AMOUNT_W-1:0] tbl_orig [TABLE_DEPTH];
    logic [AMOUNT_W-1:0] tbl_free [TABLE_DEPTH];
    logic [MODE_W-1:0]   tbl_mode;
    logic [COUNT_W-1:0]  tbl_count;

    // Predicted results, oldest first.
    fpfa_pkg::rsp_item_t expected_grants [$];

    // Idle percentages of the two sides; the main sequence sets them.
    int src_idle_pct;
    int sink_idle_pct;

    int failures;
    int mismatches;
    int requests_sent;
    int allocs_sent;
    int allocs_granted;
    int results_seen;
    int reg_writes;

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predicts the result of one operation and applies it to the shadow
    // table. Ties always fall to the lowest index because only a strictly
    // better entry replaces the current pick.
    function automatic fpfa_pkg::rsp_item_t predict_partition_op(
        input fpfa_pkg::req_item_t item);
        fpfa_pkg::rsp_item_t res;
        int                  span;
        int                  pick;
        int                  i;
        logic                hit;
        logic [AMOUNT_W-1:0] best;
        res  = '0;
        span = (tbl_count > COUNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(tbl_count);
        case (item.opcode)
            fpfa_pkg::OP_LOAD:
            begin
                // A four-bit index always lands inside the sixteen entries,
                // including entries above the count in use.
                tbl_orig[item.entry_index] = item.amount;
                tbl_free[item.entry_index] = item.amount;
                res.granted = 1'b1;
            end
            fpfa_pkg::OP_ALLOC:
            begin
                hit  = 1'b0;
                pick = 0;
                best = '0;
                for (i = 0; i < span; i++)
                begin
                    case (tbl_mode)
                        fpfa_pkg::MODE_FIRST:
                            if (!hit && tbl_free[i] >= item.amount)
                            begin
                                hit  = 1'b1;
                                pick = i;
                            end
                        fpfa_pkg::MODE_BEST:
                            if (tbl_free[i] >= item.amount &&
                                (!hit || (tbl_free[i] - item.amount) < best))
                            begin
                                hit  = 1'b1;
                                best = tbl_free[i] - item.amount;
                                pick = i;
                            end
                        fpfa_pkg::MODE_WORST:
                            if (!hit || tbl_free[i] > best)
                            begin
                                hit  = 1'b1;
                                best = tbl_free[i];
                                pick = i;
                            end
                        default: ;
                    endcase
                end
                // Worst fit only succeeds when the largest entry covers it.
                if (tbl_mode == fpfa_pkg::MODE_WORST && best < item.amount)
                    hit = 1'b0;
                if (hit)
                begin
                    tbl_free[pick]   = tbl_free[pick] - item.amount;
                    res.granted      = 1'b1;
                    res.chosen_index = pick[ENTRY_W-1:0];
                    res.leftover     = tbl_free[pick];
                end
            end
            fpfa_pkg::OP_RELEASE:
            begin
                tbl_free    = tbl_orig;
                res.granted = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Partition sizes: full range, small, and both extremes.
    function automatic logic [AMOUNT_W-1:0] pick_partition_size();
        case ($urandom_range(5))
            0:       return '1;
            1:       return '0;
            2, 3:    return AMOUNT_W'($urandom_range(255));
            default: return AMOUNT_W'($urandom);
        endcase
    endfunction

    // Requests are mostly aimed at the current free sizes so that exact
    // fits, near fits and just-too-large requests come up often.
    function automatic logic [AMOUNT_W-1:0] pick_request_amount();
        int                  span;
        logic [AMOUNT_W-1:0] f;
        span = (tbl_count > COUNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(tbl_count);
        if (span == 0)
            span = 1;
        f = tbl_free[$urandom_range(span - 1)];
        case ($urandom_range(7))
            0:       return AMOUNT_W'($urandom);
            1:       return AMOUNT_W'($urandom_range(15));
            2:       return ($urandom_range(1) != 0) ? '1 : '0;
            3:       return f;
            4:       return f + 1'b1;
            default: return f - AMOUNT_W'($urandom_range((f < 16) ? int'(f) : 16));
        endcase
    endfunction

    // Sends one request. The sender may idle first, deciding afresh at each
    // falling edge; once valid is up it stays up until the transfer happens.
    // Valid is never lowered here after a transfer, so back-to-back requests
    // keep it high across the boundary.
    task automatic send_request(input fpfa_pkg::req_item_t item);
        fpfa_pkg::rsp_item_t res;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        res = predict_partition_op(item);
        expected_grants = {expected_grants, res};
        requests_sent++;
        if (item.opcode == fpfa_pkg::OP_ALLOC)
        begin
            allocs_sent++;
            if (res.granted)
                allocs_granted++;
        end
    endtask

    // Holds the sender off until every predicted result has come back, then
    // gives the block time to finish any write-back before going on.
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Register write. Only called with the block idle.
    task automatic write_register(input logic [fpfa_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [fpfa_pkg::CFG_DATA_W-1:0]  data);
        @(negedge clk);
        cfg_if.valid             <= 1'b1;
        cfg_if.payload.reg_index <= idx;
        cfg_if.payload.data      <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == fpfa_pkg::REG_FIT_MODE)
            tbl_mode = data[MODE_W-1:0];
        else if (idx == fpfa_pkg::REG_PARTITION_COUNT)
            tbl_count = data[COUNT_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // The receiver stalls at random, decided afresh at every falling edge.
    always @(negedge clk)
        resp_if.ready <= ($urandom_range(99) >= sink_idle_pct);

    // Every response transfer is matched with the oldest prediction.
    always @(posedge clk)
    begin
        fpfa_pkg::rsp_item_t want;
        if (rst_n && resp_if.valid && resp_if.ready)
        begin
            results_seen++;
            if (expected_grants.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result granted=%0b index=%0d leftover=%0h",
                             $realtime, resp_if.payload.granted,
                             resp_if.payload.chosen_index, resp_if.payload.leftover);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (resp_if.payload.granted      !== want.granted      ||
                    resp_if.payload.chosen_index !== want.chosen_index ||
                    resp_if.payload.leftover     !== want.leftover)
                begin
                    failures++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: result mismatch, expected granted=%0b index=%0d ",
                                  "leftover=%0h, got granted=%0b index=%0d leftover=%0h"},
                                 $realtime, want.granted, want.chosen_index, want.leftover,
                                 resp_if.payload.granted, resp_if.payload.chosen_index,
                                 resp_if.payload.leftover);
                end
            end
        end
    end

    // Watchdog: ends the run when no channel has seen a transfer for too
    // long. A hung block would otherwise stall the run forever.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Directed cases: empty entries, loads above the count in use, the full
    // range of sizes, the unused opcode, tie breaking in best fit, exact
    // fit, worst fit that cannot cover the request, the unused fit mode, a
    // count of zero and a count above the table size.
    task automatic test_directed();
        src_idle_pct  = 38;
        sink_idle_pct = 69;
        // Reset settings: first fit over entry zero only.
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h0000});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h0001});
        send_request('{fpfa_pkg::OP_LOAD,    4'd15, 16'hFFFF});
        send_request('{fpfa_pkg::OP_LOAD,    4'd0,  16'hFFFF});
        send_request('{OP_UNUSED,            4'd15, 16'hFFFF});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd15, 16'hFFFF});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h0001});
        send_request('{fpfa_pkg::OP_RELEASE, 4'd0,  16'h0000});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h5555});

        wait_drained();
        write_register(fpfa_pkg::REG_PARTITION_COUNT, 5'd16);
        write_register(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::MODE_BEST});
        send_request('{fpfa_pkg::OP_LOAD,    4'd5,  16'd100});
        send_request('{fpfa_pkg::OP_LOAD,    4'd9,  16'd100});
        send_request('{fpfa_pkg::OP_LOAD,    4'd3,  16'd300});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'd90});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'd100});

        wait_drained();
        write_register(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::MODE_WORST});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h0001});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'hFFFF});

        wait_drained();
        write_register(fpfa_pkg::REG_FIT_MODE, {3'b000, MODE_UNUSED});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h0000});

        wait_drained();
        write_register(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::MODE_FIRST});
        write_register(fpfa_pkg::REG_PARTITION_COUNT, 5'd0);
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'h0000});

        wait_drained();
        write_register(fpfa_pkg::REG_PARTITION_COUNT, 5'd31);
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'hAAAB});
        send_request('{fpfa_pkg::OP_RELEASE, 4'd7,  16'h1234});
        send_request('{fpfa_pkg::OP_ALLOC,   4'd0,  16'hFFFF});
    endtask

    // Random traffic under one idle profile. Each stretch picks new
    // settings while the block is idle, loads every entry in use so the
    // searches have something to find, then runs mostly allocations with
    // loads, releases and some noise mixed in.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int item_goal);
        int                  sent;
        int                  seg_len;
        int                  span;
        int                  k;
        int                  roll;
        logic [MODE_W-1:0]   mode;
        logic [COUNT_W-1:0]  count;
        fpfa_pkg::req_item_t item;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent          = 0;
        while (sent < item_goal)
        begin
            wait_drained();
            roll = $urandom_range(9);
            mode = (roll == 0) ? MODE_UNUSED : MODE_W'($urandom_range(2));
            case ($urandom_range(9))
                0:       count = 5'd0;
                1:       count = 5'd16;
                2:       count = COUNT_W'($urandom_range(31, 17));
                3:       count = 5'd1;
                default: count = COUNT_W'($urandom_range(16, 1));
            endcase
            write_register(fpfa_pkg::REG_FIT_MODE, {3'b000, mode});
            write_register(fpfa_pkg::REG_PARTITION_COUNT, count);

            span = (count > COUNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(count);
            for (k = 0; k < span; k++)
            begin
                item.opcode      = fpfa_pkg::OP_LOAD;
                item.entry_index = ENTRY_W'(k);
                item.amount      = pick_partition_size();
                send_request(item);
                sent++;
            end

            seg_len = $urandom_range(50, 15);
            for (k = 0; k < seg_len; k++)
            begin
                roll             = $urandom_range(99);
                item.entry_index = ENTRY_W'($urandom);
                if (roll < 62)
                begin
                    item.opcode = fpfa_pkg::OP_ALLOC;
                    item.amount = pick_request_amount();
                end
                else if (roll < 80)
                begin
                    item.opcode = fpfa_pkg::OP_LOAD;
                    item.amount = pick_partition_size();
                end
                else if (roll < 90)
                begin
                    item.opcode = fpfa_pkg::OP_RELEASE;
                    item.amount = AMOUNT_W'($urandom);
                end
                else if (roll < 94)
                begin
                    item.opcode = OP_UNUSED;
                    item.amount = AMOUNT_W'($urandom);
                end
                else
                begin
                    item.opcode = fpfa_pkg::OP_ALLOC;
                    item.amount = AMOUNT_W'($urandom);
                end
                send_request(item);
                if (item.opcode != OP_UNUSED)
                    sent++;
                // Now and then the sender holds off until everything is back.
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
        end
    endtask

    // Main sequence: reset once, directed cases, then the three idle
    // profiles, then drain and report.
    initial
    begin
        int i;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        resp_if.ready  = 1'b0;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        failures       = 0;
        mismatches     = 0;
        requests_sent  = 0;
        allocs_sent    = 0;
        allocs_granted = 0;
        results_seen   = 0;
        reg_writes     = 0;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_orig[i] = '0;
            tbl_free[i] = '0;
        end
        tbl_mode  = fpfa_pkg::FIT_MODE_RST;
        tbl_count = fpfa_pkg::PARTITION_COUNT_RST;

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(38, 69, 475);
        test_random_traffic(69, 38, 475);
        test_random_traffic(0, 0, 475);
        wait_drained();

        $display("Covered %0d requests (%0d allocations, %0d granted) and %0d results,",
                 requests_sent, allocs_sent, allocs_granted, results_seen);
        $display("with %0d register writes over three idle profiles; %0d mismatches.",
                 reg_writes, mismatches);
        if (failures == 0 && expected_grants.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fpfa_pkg.sv
hdl/fpfa_stream_if.sv
hdl/fpfa_cell.sv
hdl/fixed_partition_fit_allocator.sv
sim/fixed_partition_fit_allocator_tb.sv
